// ----- rtl/sspq_pkg.sv -----
// Shared types and constants for the stable sorted priority queue.
package sspq_pkg;

	localparam int WEIGHT_BITS  = 32;
	localparam int HANDLE_BITS  = 9;
	localparam int COUNT_BITS   = 9;
	localparam int DEF_CAPACITY = 256;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                   cmd;
		logic [WEIGHT_BITS-1:0] item_weight;
		logic [HANDLE_BITS-1:0] node_handle;
	} req_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] popped_weight;
		logic [HANDLE_BITS-1:0] popped_handle;
		logic [COUNT_BITS-1:0]  entry_count;
		status_t                status;
	} rsp_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic [HANDLE_BITS-1:0] handle;
	} slot_t;

	typedef struct packed {
		logic  ins;
		logic  pop;
		slot_t entry;
	} cell_op_t;

endpackage

// ----- rtl/sspq_cell.sv -----
// One slot of the sorted queue, shifting toward its neighbors on insert and pop.
module sspq_cell (
	input  logic              clk,
	input  sspq_pkg::cell_op_t op,
	input  logic              occ,
	input  logic              left_le,
	input  sspq_pkg::slot_t   left_slot,
	input  sspq_pkg::slot_t   right_slot,
	output logic              le,
	output sspq_pkg::slot_t   slot
);
	import sspq_pkg::*;

	slot_t slot_q;
	slot_t slot_d;

	assign le   = occ && (slot_q.weight <= op.entry.weight);
	assign slot = slot_q;

	always_comb begin
		slot_d = slot_q;
		if (op.ins) begin
			if (!le) begin
				slot_d = left_le ? op.entry : left_slot;
			end
		end else if (op.pop) begin
			slot_d = right_slot;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

endmodule

// ----- rtl/sspq_out_buf.sv -----
// Two-entry response buffer between the queue and its consumer.
module sspq_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sspq_pkg::rsp_t push_data,
	output logic           can_push,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output sspq_pkg::rsp_t rsp
);
	import sspq_pkg::*;

	rsp_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       pop;

	assign can_push  = (fill_q != 2'd2);
	assign rsp_valid = (fill_q != 2'd0);
	assign rsp       = buf_q[rd_ptr_q];
	assign pop       = rsp_valid && rsp_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- rtl/stable_sorted_priority_queue.sv -----
// Top level of the stable sorted min priority queue built from a row of slot cells.
// The queue keeps up to CAPACITY entries in ascending weight order, one entry per cell,
// with equal weights kept in arrival order. Every request (insert or pop) is applied to
// all cells at once: they compare their weight against the new one in parallel and shift
// by one place toward their neighbor, so a new request can be accepted every cycle
// while the output buffer has room. Each request yields one response, held in a two-entry
// output buffer; requests stall only while both buffer entries wait to be taken. A pop
// on an empty queue or an insert on a full queue leaves the queue unchanged and reports the error in status.
module stable_sorted_priority_queue #(
	parameter int CAPACITY = sspq_pkg::DEF_CAPACITY
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  sspq_pkg::req_t cmd_req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output sspq_pkg::rsp_t rsp
);
	import sspq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             accept;
	logic             full;
	logic             empty;
	cell_op_t         op;
	rsp_t             rsp_d;
	logic             le   [CAPACITY];
	slot_t            slot [CAPACITY];

	assign accept = cmd_valid && cmd_ready;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	always_comb begin
		op.ins          = accept && (cmd_req.cmd == CMD_INSERT) && !full;
		op.pop          = accept && (cmd_req.cmd == CMD_POP) && !empty;
		op.entry.weight = cmd_req.item_weight;
		op.entry.handle = cmd_req.node_handle;
	end

	always_comb begin
		count_d = count_q;
		if (op.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (op.pop) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		rsp_d.popped_weight = '0;
		rsp_d.popped_handle = '0;
		rsp_d.entry_count   = COUNT_BITS'(count_d);
		rsp_d.status        = STATUS_OK;
		if (cmd_req.cmd == CMD_POP) begin
			if (empty) begin
				rsp_d.status = STATUS_EMPTY;
			end else begin
				rsp_d.popped_weight = slot[0].weight;
				rsp_d.popped_handle = slot[0].handle;
			end
		end else if (full) begin
			rsp_d.status = STATUS_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic  occ;
		logic  left_le;
		slot_t left_slot;
		slot_t right_slot;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_le   = 1'b0;
			assign left_slot = op.entry;
		end else begin : g_body
			assign left_le   = le[i-1];
			assign left_slot = slot[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_slot = slot[i];
		end else begin : g_inner
			assign right_slot = slot[i+1];
		end

		sspq_cell u_cell (
			.clk        (clk),
			.op         (op),
			.occ        (occ),
			.left_le    (left_le),
			.left_slot  (left_slot),
			.right_slot (right_slot),
			.le         (le[i]),
			.slot       (slot[i])
		);
	end

	sspq_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (rsp_d),
		.can_push  (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
